@@ rtl/mbmm_pkg.sv @@
// Package for the MIDI button mode mapper: message kinds, button modes,
// looper phases, register indexes and the step value table lookup.
// Has no dependencies; every other file imports it.
package mbmm_pkg;

  localparam int unsigned NumW     = 7;
  localparam int unsigned ChanW    = 4;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned StepIdxW = 3;
  localparam int unsigned TableEntries = 5;
  localparam int unsigned TableW   = TableEntries * NumW;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [NumW-1:0] CmdRecord  = 7'd120;
  localparam logic [NumW-1:0] CmdPlay    = 7'd121;
  localparam logic [NumW-1:0] CmdOverdub = 7'd122;
  localparam logic [NumW-1:0] CmdStop    = 7'd123;
  localparam logic [NumW-1:0] CmdClear   = 7'd124;
  localparam logic [NumW-1:0] CmdUndo    = 7'd125;
  localparam logic [NumW-1:0] ValFull    = 7'd127;
  localparam logic [NumW-1:0] ValZero    = 7'd0;
  localparam logic [NumW-1:0] OffsUp     = 7'd32;
  localparam logic [NumW-1:0] OffsDownMp = 7'd64;
  localparam logic [NumW-1:0] OffsDownIc = 7'd24;
  localparam logic [TimeW-1:0] TimeMax   = 16'hFFFF;
  localparam logic [TimeW-1:0] DoubleClickReset = 16'd300;
  localparam logic [TimeW-1:0] LongPressReset   = 16'd2000;

  typedef enum logic [1:0] {
    KIND_ON    = 2'd0,
    KIND_OFF   = 2'd1,
    KIND_CC    = 2'd2,
    KIND_OTHER = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    MODE_STANDARD   = 3'd0,
    MODE_TOGGLE     = 3'd1,
    MODE_TOGGLE_CC  = 3'd2,
    MODE_MULTIPRESS = 3'd3,
    MODE_INC_CC     = 3'd4,
    MODE_LOOPER     = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    PH_NONE    = 3'd0,
    PH_CLEAR   = 3'd1,
    PH_RECORD  = 3'd2,
    PH_PLAY    = 3'd3,
    PH_OVERDUB = 3'd4,
    PH_STOP    = 3'd5
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BUTTON_MODE    = 3'd0,
    REG_LOOPER_CHANNEL = 3'd1,
    REG_DOUBLE_CLICK   = 3'd2,
    REG_LONG_PRESS     = 3'd3,
    REG_STEP_TABLE     = 3'd4
  } cfg_reg_e;

  // Entries past the end of the packed table read as zero.
  function automatic logic [NumW-1:0] step_entry(input logic [TableW-1:0] tbl,
                                                 input logic [StepIdxW-1:0] idx);
    logic [NumW-1:0] val;
    val = '0;
    for (int i = 0; i < TableEntries; i++) begin
      if (idx == StepIdxW'(i)) begin
        val = tbl[i*NumW +: NumW];
      end
    end
    return val;
  endfunction

endpackage

@@ rtl/midi_button_mode_mapper_top.sv @@
// MIDI button mode mapper, top level: input register, single-pass rewrite
// logic and a result register. Depends on mbmm_pkg.
//
//   channel | handshake                  | moves
//   --------+----------------------------+----------------------------------
//   in      | in_valid_i / in_stall_o    | one message or 1 ms tick
//   out     | out_valid_o / out_stall_i  | zero or one rewritten message
//   cfg     | cfg_valid_i / cfg_ready_o  | register index and write data
//
// One transaction enters per cycle while in_stall_o is low. Its result goes
// to the output ports via the input register, then the result register.
// A tick usually makes no result.
// State and valid flops clear on rst_ni (payloads do not); no clearing pass.
// A stall on the output holds the result register, and the input register
// then holds its item and raises in_stall_o.
module midi_button_mode_mapper_top #(
  parameter int unsigned STEP_COUNT = 5
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            req_type_i,
  input  logic [1:0]                      msg_kind_i,
  input  logic [mbmm_pkg::ChanW-1:0]      chan_i,
  input  logic [mbmm_pkg::NumW-1:0]       data_number_i,
  input  logic [mbmm_pkg::NumW-1:0]       data_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      out_kind_o,
  output logic [mbmm_pkg::ChanW-1:0]      out_chan_o,
  output logic [mbmm_pkg::NumW-1:0]       out_number_o,
  output logic [mbmm_pkg::NumW-1:0]       out_value_o,
  output logic                            from_timer_o,
  output logic                            lamp_on_o,
  output logic [2:0]                      looper_phase_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mbmm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [mbmm_pkg::TableW-1:0]     cfg_data_i
);
  import mbmm_pkg::*;

  localparam logic [StepIdxW-1:0] MaxIdx = StepIdxW'(STEP_COUNT - 1);

  // Input register.
  logic              s1_valid_q;
  logic              s1_tick_q;
  kind_e             s1_kind_q;
  logic [ChanW-1:0]  s1_chan_q;
  logic [NumW-1:0]   s1_num_q;
  logic [NumW-1:0]   s1_val_q;

  // Configuration.
  mode_e             mode_q, mode_d;
  logic [ChanW-1:0]  loop_chan_q, loop_chan_d;
  logic [TimeW-1:0]  dclick_q, dclick_d;
  logic [TimeW-1:0]  lpress_q, lpress_d;
  logic [TableW-1:0] table_q, table_d;

  // Block state.
  logic              lamp_q, lamp_d;
  logic              rel_off_q, rel_off_d;
  logic              skip_rel_q, skip_rel_d;
  logic [StepIdxW-1:0] step_idx_q, step_idx_d;
  phase_e            phase_q, phase_d;
  logic              clr_lp_q, clr_lp_d;
  logic [TimeW-1:0]  since_q, since_d;
  logic [TimeW-1:0]  ptimer_q, ptimer_d;
  logic              prun_q, prun_d;

  // Result register.
  logic              out_valid_q;
  kind_e             out_kind_q;
  logic [ChanW-1:0]  out_chan_q;
  logic [NumW-1:0]   out_num_q;
  logic [NumW-1:0]   out_val_q;
  logic              out_timer_q;
  logic              out_lamp_q;
  phase_e            out_phase_q;

  // Result of the current step.
  logic              res_en;
  kind_e             res_kind;
  logic [ChanW-1:0]  res_chan;
  logic [NumW-1:0]   res_num;
  logic [NumW-1:0]   res_val;
  logic              res_timer;

  logic advance;
  logic in_accept;
  logic [TimeW-1:0] ptimer_inc;
  logic note_on;
  logic note_off;
  logic is_up;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign note_on    = (s1_kind_q == KIND_ON);
  assign note_off   = (s1_kind_q == KIND_OFF);
  assign is_up      = (s1_val_q == ValFull);
  assign ptimer_inc = (ptimer_q != TimeMax) ? ptimer_q + TimeW'(1) : ptimer_q;

  always_comb begin
    mode_d      = mode_q;
    loop_chan_d = loop_chan_q;
    dclick_d    = dclick_q;
    lpress_d    = lpress_q;
    table_d     = table_q;
    lamp_d      = lamp_q;
    rel_off_d   = rel_off_q;
    skip_rel_d  = skip_rel_q;
    step_idx_d  = step_idx_q;
    phase_d     = phase_q;
    clr_lp_d    = clr_lp_q;
    since_d     = since_q;
    ptimer_d    = ptimer_q;
    prun_d      = prun_q;
    res_en      = 1'b0;
    res_kind    = s1_kind_q;
    res_chan    = s1_chan_q;
    res_num     = s1_num_q;
    res_val     = s1_val_q;
    res_timer   = 1'b0;

    if (advance) begin
      if (s1_tick_q) begin
        if (since_q != TimeMax) begin
          since_d = since_q + TimeW'(1);
        end
        if (prun_q) begin
          // A limit of zero fires on the first tick, the same as one.
          if (ptimer_inc < lpress_q) begin
            ptimer_d = ptimer_inc;
          end else begin
            prun_d   = 1'b0;
            ptimer_d = '0;
            clr_lp_d = 1'b0;
            if (lamp_q) begin
              res_en    = 1'b1;
              res_kind  = KIND_ON;
              res_chan  = loop_chan_q;
              res_val   = ValFull;
              res_timer = 1'b1;
              if (clr_lp_q) begin
                phase_d = PH_CLEAR;
                res_num = CmdClear;
              end else begin
                res_num = CmdUndo;
              end
            end
          end
        end
      end else begin
        res_en = 1'b1;
        if (note_on) begin
          since_d = '0;
        end
        case (mode_q)
          MODE_STANDARD: begin
            lamp_d = note_on;
          end
          MODE_TOGGLE: begin
            if (note_on) begin
              lamp_d = !lamp_q;
              if (lamp_q) begin
                res_val = ValZero;
              end
            end
          end
          MODE_TOGGLE_CC: begin
            if (rel_off_q) begin
              if (note_off) begin
                res_kind  = KIND_CC;
                res_val   = ValZero;
                rel_off_d = 1'b0;
                lamp_d    = 1'b0;
              end
            end else if (note_on) begin
              if (!lamp_q) begin
                lamp_d   = 1'b1;
                res_kind = KIND_CC;
                res_val  = ValFull;
              end else begin
                rel_off_d = 1'b1;
              end
            end
          end
          MODE_MULTIPRESS, MODE_INC_CC: begin
            if (note_off) begin
              if (!skip_rel_q) begin
                lamp_d   = !lamp_q;
                res_kind = KIND_CC;
                res_val  = lamp_q ? ValZero : ValFull;
              end else begin
                skip_rel_d = 1'b0;
              end
            end else if (s1_kind_q == KIND_CC && (is_up || s1_val_q == ValZero)) begin
              skip_rel_d = 1'b1;
              if (mode_q == MODE_MULTIPRESS) begin
                res_kind = KIND_ON;
                res_num  = s1_num_q + (is_up ? OffsUp : OffsDownMp);
                res_val  = ValFull;
              end else begin
                if (is_up) begin
                  if (step_idx_q < MaxIdx) begin
                    step_idx_d = step_idx_q + StepIdxW'(1);
                  end
                end else if (step_idx_q != '0) begin
                  step_idx_d = step_idx_q - StepIdxW'(1);
                end
                res_kind = KIND_CC;
                res_num  = s1_num_q + (is_up ? OffsUp : OffsDownIc);
                res_val  = step_entry(table_q, step_idx_d);
              end
            end
          end
          MODE_LOOPER: begin
            if (note_on) begin
              lamp_d   = 1'b1;
              prun_d   = 1'b1;
              ptimer_d = '0;
              res_kind = KIND_ON;
              res_chan = loop_chan_q;
              res_val  = ValFull;
              if (since_q < dclick_q) begin
                if (phase_q != PH_CLEAR) begin
                  res_num = CmdStop;
                  phase_d = PH_STOP;
                end else begin
                  res_num = CmdClear;
                end
              end else begin
                case (phase_q)
                  PH_CLEAR: begin
                    res_num = CmdRecord;
                    phase_d = PH_RECORD;
                  end
                  PH_RECORD: begin
                    res_num = CmdPlay;
                    phase_d = PH_PLAY;
                  end
                  PH_PLAY: begin
                    res_num = CmdOverdub;
                    phase_d = PH_OVERDUB;
                  end
                  PH_OVERDUB: begin
                    res_num = CmdPlay;
                    phase_d = PH_PLAY;
                  end
                  PH_STOP: begin
                    res_num  = CmdPlay;
                    clr_lp_d = 1'b1;
                    phase_d  = PH_PLAY;
                  end
                  default: begin
                    // No looper phase: the message goes on unchanged.
                    res_kind = s1_kind_q;
                    res_chan = s1_chan_q;
                    res_val  = s1_val_q;
                  end
                endcase
              end
            end else if (note_off) begin
              lamp_d = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end

    // User keeps configuration writes off in-flight transactions; unchecked.
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_BUTTON_MODE: begin
          if (cfg_data_i[2:0] <= MODE_LOOPER) begin
            mode_d = mode_e'(cfg_data_i[2:0]);
            if (cfg_data_i[2:0] == MODE_LOOPER) begin
              if (phase_q == PH_NONE) begin
                phase_d = PH_CLEAR;
              end
            end else begin
              phase_d = PH_NONE;
            end
          end
        end
        REG_LOOPER_CHANNEL: loop_chan_d = cfg_data_i[ChanW-1:0];
        REG_DOUBLE_CLICK:   dclick_d    = cfg_data_i[TimeW-1:0];
        REG_LONG_PRESS:     lpress_d    = cfg_data_i[TimeW-1:0];
        REG_STEP_TABLE:     table_d     = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      mode_q      <= MODE_STANDARD;
      loop_chan_q <= '0;
      dclick_q    <= DoubleClickReset;
      lpress_q    <= LongPressReset;
      table_q     <= '0;
      lamp_q      <= 1'b0;
      rel_off_q   <= 1'b0;
      skip_rel_q  <= 1'b0;
      step_idx_q  <= '0;
      phase_q     <= PH_CLEAR;
      clr_lp_q    <= 1'b0;
      since_q     <= TimeMax;
      ptimer_q    <= '0;
      prun_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      loop_chan_q <= loop_chan_d;
      dclick_q    <= dclick_d;
      lpress_q    <= lpress_d;
      table_q     <= table_d;
      lamp_q      <= lamp_d;
      rel_off_q   <= rel_off_d;
      skip_rel_q  <= skip_rel_d;
      step_idx_q  <= step_idx_d;
      phase_q     <= phase_d;
      clr_lp_q    <= clr_lp_d;
      since_q     <= since_d;
      ptimer_q    <= ptimer_d;
      prun_q      <= prun_d;
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance && res_en) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_tick_q <= req_type_i;
      s1_kind_q <= kind_e'(msg_kind_i);
      s1_chan_q <= chan_i;
      s1_num_q  <= data_number_i;
      s1_val_q  <= data_value_i;
    end
    if (advance && res_en) begin
      out_kind_q  <= res_kind;
      out_chan_q  <= res_chan;
      out_num_q   <= res_num;
      out_val_q   <= res_val;
      out_timer_q <= res_timer;
      out_lamp_q  <= lamp_d;
      out_phase_q <= phase_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = out_kind_q;
  assign out_chan_o     = out_chan_q;
  assign out_number_o   = out_num_q;
  assign out_value_o    = out_val_q;
  assign from_timer_o   = out_timer_q;
  assign lamp_on_o      = out_lamp_q;
  assign looper_phase_o = out_phase_q;

endmodule

@@ rtl/mbmm_checker.sv @@
// Port-level checks for the MIDI button mode mapper, bound to the top level.
// Depends on mbmm_pkg and the port names of midi_button_mode_mapper_top.
module mbmm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [1:0]                    out_kind_o,
  input logic [mbmm_pkg::NumW-1:0]     out_number_o,
  input logic [mbmm_pkg::NumW-1:0]     out_value_o,
  input logic                          from_timer_o,
  input logic                          lamp_on_o,
  input logic [2:0]                    looper_phase_o
);
  import mbmm_pkg::*;

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(out_kind_o) && $stable(out_number_o) && $stable(out_value_o))
    else $error("stalled result changed");

  // A long-press message is a full-velocity clear or undo with the lamp on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && from_timer_o |->
      out_kind_o == KIND_ON && out_value_o == ValFull && lamp_on_o &&
      (out_number_o == CmdClear || out_number_o == CmdUndo))
    else $error("malformed long-press message");

  // A long-press clear always leaves the looper in the clear phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && from_timer_o && out_number_o == CmdClear |->
      looper_phase_o == PH_CLEAR)
    else $error("long-press clear left looper out of clear phase");

endmodule

bind midi_button_mode_mapper_top mbmm_checker u_mbmm_checker (.*);
